[rtl/bfa_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package bfa_pkg;

  localparam int MAX_BLOCK_COUNT = 1024;
  localparam int MAP_WORD_BITS   = 32;
  localparam int MAP_WORDS       = (MAX_BLOCK_COUNT + MAP_WORD_BITS - 1) / MAP_WORD_BITS;

  localparam int BLK_W   = 10;                        // block_index / granted_index
  localparam int CNT_W   = 11;                        // counts and limit
  localparam int STAT_W  = 2;
  localparam int BIT_W   = $clog2(MAP_WORD_BITS);     // bit within a map word
  localparam int WADDR_W = $clog2(MAP_WORDS);         // map word address
  localparam int WCNT_W  = WADDR_W + 1;               // word counter, holds MAP_WORDS

  localparam logic [0:0] CMD_ALLOC = 1'b0;
  localparam logic [0:0] CMD_FREE  = 1'b1;

  localparam logic [STAT_W-1:0] STATUS_OK       = 2'd0;
  localparam logic [STAT_W-1:0] STATUS_FULL     = 2'd1;
  localparam logic [STAT_W-1:0] STATUS_NOT_USED = 2'd2;

  typedef logic [MAP_WORD_BITS-1:0] map_word_t;

  // Lowest set bit of a map word; zero when the word is empty.
  function automatic logic [BIT_W-1:0] lowest_set(input map_word_t v);
    logic [BIT_W-1:0] pos;
    pos = '0;
    for (int i = MAP_WORD_BITS - 1; i >= 0; i--) begin
      if (v[i]) begin
        pos = i[BIT_W-1:0];
      end
    end
    return pos;
  endfunction

  // Bits of a map word that lie below the limit: lo low bits set.
  function automatic map_word_t low_mask(input logic [BIT_W-1:0] lo);
    map_word_t m;
    for (int i = 0; i < MAP_WORD_BITS; i++) begin
      m[i] = (i < int'(lo));
    end
    return m;
  endfunction

endpackage
`default_nettype wire

[rtl/bfa_ram.sv]
`timescale 1ns / 1ps
`default_nettype none
module bfa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

[rtl/bitmap_first_fit_block_allocator_unit.sv]
`timescale 1ns / 1ps
`default_nettype none
// Sequence: a free reads the map word of its block; an allocate reads map words from word 0
//   until one holds a free bit or the limit is reached; the result is registered from the last word read.
// Throughput: one item at a time, the next taken once the last is done; the scan pace is
//   set by the single read port of the bitmap RAM walked one word a cycle through the
//   per-word priority encoder; a stalled result holds the final step of the item behind it.
// Reset (rst, synchronous): bitmap reads as all free via per-word valid bits, count zero,
//   limit 1024, no result pending; no clearing pass is needed.
module bitmap_first_fit_block_allocator_unit (
  input  wire logic                        clk,
  input  wire logic                        rst,
  // request channel
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic [0:0]                  command,
  input  wire logic [bfa_pkg::BLK_W-1:0]   block_index,
  // result channel
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic      [bfa_pkg::STAT_W-1:0]  status,
  output logic      [bfa_pkg::BLK_W-1:0]   granted_index,
  output logic      [bfa_pkg::CNT_W-1:0]   free_count,
  // limit register write
  input  wire logic                        cfg_valid,
  output logic                             cfg_ready,
  input  wire logic [bfa_pkg::CNT_W-1:0]   cfg_data
);
  import bfa_pkg::*;

  localparam logic [0:0] ST_IDLE  = 1'b0;
  localparam logic [0:0] ST_CHECK = 1'b1;

  logic [0:0]         state;
  logic [0:0]         cmd_r;
  logic [BLK_W-1:0]   idx_r;
  logic [WCNT_W-1:0]  word;          // map word scanned by an allocate, whose data sits on the RAM output
  logic [CNT_W-1:0]   used_count;
  logic [CNT_W-1:0]   limit;
  logic [MAP_WORDS-1:0] row_valid;   // a row never written reads as all free
  logic               rd_row_valid;

  // RAM interface
  logic               ram_we;
  logic [WADDR_W-1:0] ram_waddr;
  map_word_t          ram_wdata;
  logic               ram_re;
  logic [WADDR_W-1:0] ram_raddr;
  map_word_t          ram_rdata;

  bfa_ram #(
    .WIDTH (MAP_WORD_BITS),
    .DEPTH (MAP_WORDS)
  ) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Effective limit: clamp to the bitmap capacity.
  localparam logic [CNT_W-1:0] CAP = CNT_W'(MAX_BLOCK_COUNT);
  logic [CNT_W-1:0]  lim;
  logic [CNT_W-1:0]  lim_round;
  logic [WCNT_W-1:0] nwords;         // map words holding any bit below the limit
  logic [WCNT_W-1:0] lim_hi;
  logic [BIT_W-1:0]  lim_lo;

  assign lim       = (limit > CAP) ? CAP : limit;
  assign lim_round = lim + CNT_W'(MAP_WORD_BITS - 1);
  assign nwords    = lim_round[CNT_W-1:BIT_W];
  assign lim_hi    = lim[CNT_W-1:BIT_W];
  assign lim_lo    = lim[BIT_W-1:0];

  // Word check
  map_word_t         row;
  map_word_t         mask;
  map_word_t         free_bits;
  logic              found;
  logic [BIT_W-1:0]  bitpos;
  logic              last;
  logic              hit;
  logic              done;
  logic              out_free;
  logic              finish;
  logic [WCNT_W-1:0] word_inc;
  logic [CNT_W-1:0]  count_new;

  assign row       = rd_row_valid ? ram_rdata : '0;
  assign free_bits = ~row & mask;
  assign found     = |free_bits;
  assign bitpos    = lowest_set(free_bits);
  assign word_inc  = word + WCNT_W'(1);
  assign last      = (word_inc >= nwords);
  assign hit       = row[idx_r[BIT_W-1:0]];
  assign done      = (cmd_r == CMD_FREE) || found || last;
  // Hold the final step while an earlier result still waits downstream.
  assign out_free  = !out_valid || !out_stall;
  assign finish    = (state == ST_CHECK) && done && out_free;

  always_comb begin
    if (word < lim_hi) begin
      mask = '1;
    end else if (word == lim_hi) begin
      mask = low_mask(lim_lo);
    end else begin
      mask = '0;
    end
  end

  // Accept only between items; a waiting result does not block the next request.
  assign in_stall  = (state != ST_IDLE);
  assign cfg_ready = 1'b1;

  always_comb begin
    ram_re    = 1'b0;
    ram_raddr = '0;
    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_wdata = row;
    count_new = used_count;
    if (state == ST_IDLE) begin
      // Start the read of the first word as the item is taken.
      ram_re    = in_valid;
      ram_raddr = (command == CMD_FREE) ? block_index[BLK_W-1:BIT_W] : '0;
    end else if (!done) begin
      // Advance the scan to the next word.
      ram_re    = 1'b1;
      ram_raddr = word_inc[WADDR_W-1:0];
    end else if (finish) begin
      if (cmd_r == CMD_ALLOC) begin
        if (found) begin
          ram_we    = 1'b1;
          ram_waddr = word[WADDR_W-1:0];
          ram_wdata = row | (map_word_t'(1) << bitpos);
          count_new = used_count + CNT_W'(1);
        end
      end else if (hit) begin
        ram_we    = 1'b1;
        ram_waddr = idx_r[BLK_W-1:BIT_W];
        ram_wdata = row & ~(map_word_t'(1) << idx_r[BIT_W-1:0]);
        if (used_count != '0) begin
          count_new = used_count - CNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      used_count <= '0;
      limit      <= CAP;
      row_valid  <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        limit <= cfg_data;
      end
      if (ram_we) begin
        row_valid[ram_waddr] <= 1'b1;
      end
      used_count <= count_new;

      unique case (state)
        ST_IDLE: begin
          if (in_valid) begin
            state <= ST_CHECK;
          end
        end
        ST_CHECK: begin
          if (finish) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase

      if (finish) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers: no reset needed.
  always_ff @(posedge clk) begin
    if (ram_re) begin
      rd_row_valid <= row_valid[ram_raddr];
    end
    if (state == ST_IDLE && in_valid) begin
      cmd_r <= command;
      idx_r <= block_index;
      word  <= '0;
    end else if (state == ST_CHECK && !done) begin
      word <= word_inc;
    end
    if (finish) begin
      free_count <= (count_new > lim) ? '0 : (lim - count_new);
      if (cmd_r == CMD_ALLOC) begin
        status        <= found ? STATUS_OK : STATUS_FULL;
        granted_index <= found ? {word[WADDR_W-1:0], bitpos} : '0;
      end else begin
        status        <= hit ? STATUS_OK : STATUS_NOT_USED;
        granted_index <= '0;
      end
    end
  end

endmodule
`default_nettype wire

[rtl/bfa_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
module bfa_checker (
  input wire logic                       clk,
  input wire logic                       rst,
  input wire logic                       in_valid,
  input wire logic                       in_stall,
  input wire logic                       out_valid,
  input wire logic                       out_stall,
  input wire logic [bfa_pkg::STAT_W-1:0] status,
  input wire logic [bfa_pkg::BLK_W-1:0]  granted_index,
  input wire logic [bfa_pkg::CNT_W-1:0]  free_count
);
  import bfa_pkg::*;

  // No result straight after reset.
  a_reset_clears: assert property (@(posedge clk) $past(rst) |-> !out_valid)
    else $error("result valid after reset");

  // One item at a time: busy in the cycle after an item is taken.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("request taken while an item is in flight");

  // Full means no block left below the limit and no grant.
  a_full_result: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == STATUS_FULL |-> free_count == '0 && granted_index == '0)
    else $error("full result with free blocks or a grant");

  // Hold a stalled result.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(status) && $stable(granted_index)
      && $stable(free_count))
    else $error("stalled result changed");

endmodule

bind bitmap_first_fit_block_allocator_unit bfa_checker u_bfa_checker (.*);
`default_nettype wire

[test/tb_top.sv]
`timescale 1ns / 1ps
module tb_top;
  import bfa_pkg::*;

  localparam int CYCLE_LIMIT    = 400000;
  localparam int HOLDOFF_CYCLES = 300;
  localparam int DRAIN_CYCLES   = 40;
  localparam int REPORT_LIMIT   = 10;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [BLK_W-1:0]  granted;
    logic [CNT_W-1:0]  free;
  } alloc_result_t;

  logic clk = 1'b0;
  logic rst;

  logic              in_valid;
  logic              in_stall;
  logic [0:0]        command;
  logic [BLK_W-1:0]  block_index;
  logic              out_valid;
  logic              out_stall;
  logic [STAT_W-1:0] status;
  logic [BLK_W-1:0]  granted_index;
  logic [CNT_W-1:0]  free_count;
  logic              cfg_valid;
  logic              cfg_ready;
  logic [CNT_W-1:0]  cfg_data;

  // Shadow of the allocator: bitmap, count in use and the limit register.
  bit               used_blocks [MAX_BLOCK_COUNT];
  int               used_count_model = 0;
  logic [CNT_W-1:0] limit_model      = CNT_W'(1024);

  alloc_result_t pending_results [$];

  int send_idle_pct   = 0;
  int recv_idle_pct   = 0;
  int holdoff_request = 0;
  int holdoff_left    = 0;
  int mismatch_count  = 0;
  int cycle_count     = 0;

  bitmap_first_fit_block_allocator_unit u_top (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .command       (command),
    .block_index   (block_index),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .status        (status),
    .granted_index (granted_index),
    .free_count    (free_count),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Hard stop: a hung handshake must not run forever.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Work out the result of one accepted request and advance the shadow state.
  function automatic alloc_result_t predict_request(input logic [0:0] cmd,
                                                    input logic [BLK_W-1:0] idx);
    alloc_result_t r;
    int lim;
    int slot;
    lim = (int'(limit_model) > MAX_BLOCK_COUNT) ? MAX_BLOCK_COUNT : int'(limit_model);
    r.status  = STATUS_OK;
    r.granted = '0;
    if (cmd == CMD_ALLOC) begin
      slot = -1;
      for (int i = 0; i < lim && slot < 0; i++) begin
        if (!used_blocks[i]) slot = i;
      end
      if (slot >= 0) begin
        used_blocks[slot] = 1'b1;
        used_count_model++;
        r.granted = BLK_W'(slot);
      end else begin
        r.status = STATUS_FULL;
      end
    end else begin
      // A free beyond the limit still clears the bit if it is set.
      if (int'(idx) < MAX_BLOCK_COUNT && used_blocks[idx]) begin
        used_blocks[idx] = 1'b0;
        if (used_count_model > 0) used_count_model--;
      end else begin
        r.status = STATUS_NOT_USED;
      end
    end
    // Saturate at zero once the limit has been lowered below the blocks in use.
    r.free = (used_count_model > lim) ? '0 : CNT_W'(lim - used_count_model);
    return r;
  endfunction

  // Pick a block that is in use, starting the search at a random point.
  function automatic int pick_used_block();
    int start;
    int found;
    start = $urandom_range(0, MAX_BLOCK_COUNT - 1);
    found = -1;
    for (int k = 0; k < MAX_BLOCK_COUNT && found < 0; k++) begin
      if (used_blocks[(start + k) % MAX_BLOCK_COUNT]) found = (start + k) % MAX_BLOCK_COUNT;
    end
    return found;
  endfunction

  // Offer one item, idling at random first; return once it has been taken.
  task automatic send_item(input logic [0:0] cmd, input logic [BLK_W-1:0] idx);
    alloc_result_t exp;
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid    <= 1'b1;
    command     <= cmd;
    block_index <= idx;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    exp = predict_request(cmd, idx);
    pending_results.push_back(exp);
  endtask

  task automatic release_sender();
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  task automatic wait_results_drained();
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Write the limit register; only done with the sender quiet and nothing in flight.
  task automatic set_block_limit(input logic [CNT_W-1:0] value);
    release_sender();
    wait_results_drained();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    limit_model = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Mostly well-formed traffic: allocations and frees of blocks in use,
  // with some frees of random indices as noise.
  task automatic run_traffic(input int n_items, input int alloc_pct, input int noise_pct);
    int roll;
    int victim;
    for (int k = 0; k < n_items; k++) begin
      roll   = $urandom_range(0, 99);
      victim = pick_used_block();
      if (roll < noise_pct) begin
        send_item(CMD_FREE, BLK_W'($urandom_range(0, MAX_BLOCK_COUNT - 1)));
      end else if (roll < noise_pct + alloc_pct || victim < 0) begin
        send_item(CMD_ALLOC, BLK_W'($urandom_range(0, MAX_BLOCK_COUNT - 1)));
      end else begin
        send_item(CMD_FREE, BLK_W'(victim));
      end
    end
  endtask

  // Reset limit, lowest-first grants, double free and free of a block never used.
  task automatic test_basic_alloc_free();
    send_item(CMD_ALLOC, '0);
    send_item(CMD_ALLOC, '1);
    send_item(CMD_ALLOC, BLK_W'(512));
    send_item(CMD_FREE, BLK_W'(1));
    send_item(CMD_FREE, BLK_W'(1));
    send_item(CMD_ALLOC, '0);
    send_item(CMD_FREE, BLK_W'(1023));
    send_item(CMD_FREE, BLK_W'(0));
    send_item(CMD_ALLOC, '0);
  endtask

  // Limit of zero, limit below blocks in use, free beyond the limit,
  // allocate when full and a limit above capacity.
  task automatic test_limit_corners();
    set_block_limit('0);
    send_item(CMD_ALLOC, '0);
    send_item(CMD_FREE, BLK_W'(2));
    set_block_limit(CNT_W'(4));
    send_item(CMD_ALLOC, '0);
    send_item(CMD_ALLOC, '0);
    send_item(CMD_ALLOC, '0);
    set_block_limit('1);
    send_item(CMD_ALLOC, '0);
    send_item(CMD_FREE, BLK_W'(1023));
    set_block_limit(CNT_W'(1));
    send_item(CMD_ALLOC, '0);
    send_item(CMD_FREE, BLK_W'(0));
    send_item(CMD_ALLOC, '0);
  endtask

  // Small pool that fills up often.
  task automatic test_contended_small_pool();
    set_block_limit(CNT_W'(48));
    run_traffic(400, 55, 10);
  endtask

  // Full-size pool, allocation heavy so the bitmap spreads over many words.
  task automatic test_wide_pool();
    set_block_limit(CNT_W'(1024));
    run_traffic(200, 65, 10);
    set_block_limit('1);
    run_traffic(200, 65, 10);
  endtask

  // Shrink the limit under the blocks in use: saturated counts, frees above the limit.
  task automatic test_shrunk_limit();
    set_block_limit(CNT_W'($urandom_range(1, 64)));
    run_traffic(200, 40, 15);
    set_block_limit(CNT_W'($urandom_range(65, 1100)));
    run_traffic(150, 50, 10);
  endtask

  // Hold the result channel off so the block backs up onto its input,
  // then pause the sender until every result is home.
  task automatic test_output_holdoff();
    holdoff_request = HOLDOFF_CYCLES;
    run_traffic(30, 50, 10);
    release_sender();
    wait_results_drained();
    run_traffic(30, 50, 10);
  endtask

  // Receiver: random stalls, or a long hold-off when one is asked for.
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (holdoff_request > 0) begin
        holdoff_left    = holdoff_request;
        holdoff_request = 0;
      end
      if (holdoff_left > 0) begin
        out_stall <= 1'b1;
        holdoff_left--;
      end else begin
        out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
      end
    end
  end

  // Compare each accepted result with the oldest outstanding prediction.
  always @(posedge clk) begin
    alloc_result_t exp;
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        if (mismatch_count < REPORT_LIMIT)
          $display("unexpected result: status %0d granted %0d free %0d",
                   status, granted_index, free_count);
        mismatch_count++;
      end else begin
        exp = pending_results.pop_front();
        if (status !== exp.status || granted_index !== exp.granted ||
            free_count !== exp.free) begin
          if (mismatch_count < REPORT_LIMIT)
            $display("mismatch: status exp %0d got %0d, granted exp %0d got %0d, free exp %0d got %0d",
                     exp.status, status, exp.granted, granted_index, exp.free, free_count);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    rst         = 1'b1;
    in_valid    = 1'b0;
    command     = CMD_ALLOC;
    block_index = '0;
    cfg_valid   = 1'b0;
    cfg_data    = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    send_idle_pct = 30;
    recv_idle_pct = 48;
    test_basic_alloc_free();
    test_limit_corners();
    test_contended_small_pool();

    send_idle_pct = 48;
    recv_idle_pct = 30;
    test_wide_pool();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_shrunk_limit();
    test_output_holdoff();

    release_sender();
    wait_results_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/bfa_pkg.sv
rtl/bfa_ram.sv
rtl/bitmap_first_fit_block_allocator_unit.sv
rtl/bfa_checker.sv
test/tb_top.sv
